// ===== hdl/bounded_deque_defines.svh =====
// Assertion macros used by the checker file of the deque.
`ifndef BOUNDED_DEQUE_DEFINES_SVH
`define BOUNDED_DEQUE_DEFINES_SVH

// Check that is masked while reset is high.
`define BDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bounded_deque check failed");

// Check that also covers the cycles of reset.
`define BDQ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bounded_deque reset check failed");

`endif

// ===== hdl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int CFG_W  = 11;
  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  localparam logic [CFG_W-1:0]  CAPACITY_RESET = 11'd1024;
  localparam logic [WORD_W-1:0] EMPTY_WORD     = '1;

  typedef struct packed {
    logic [CFG_W-1:0]  entry_count;
    logic              is_full;
    logic              is_empty;
    logic [WORD_W-1:0] rear_value;
    logic [WORD_W-1:0] front_value;
    logic              ok;
  } bdq_result_t;

endpackage

// ===== hdl/bdq_store.sv =====
module bdq_store #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DATA_WIDTH-1:0]    rdata_a,
  output logic [DATA_WIDTH-1:0]    rdata_b
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // controller never reads and writes in the same cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hdl/bdq_ctrl.sv =====
module bdq_ctrl #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bdq_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [bdq_pkg::CMD_W-1:0]    s_cmd,
  input  logic [bdq_pkg::WORD_W-1:0]   s_push_value,
  output logic                         m_valid,
  input  logic                         m_ready,
  output bdq_pkg::bdq_result_t         m_result,
  output logic                         mem_we,
  output logic [$clog2(DEPTH)-1:0]     mem_waddr,
  output logic [DATA_WIDTH-1:0]        mem_wdata,
  output logic                         mem_re,
  output logic [$clog2(DEPTH)-1:0]     mem_raddr_a,
  output logic [$clog2(DEPTH)-1:0]     mem_raddr_b,
  input  logic [DATA_WIDTH-1:0]        mem_rdata_a,
  input  logic [DATA_WIDTH-1:0]        mem_rdata_b
);
  import bdq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CAPTURE} state_t;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] prev_slot(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [WORD_W-1:0] to_word(input logic [DATA_WIDTH-1:0] d);
    logic signed [DATA_WIDTH-1:0] s;
    s = d;
    return WORD_W'(s);
  endfunction

  state_t           state;
  logic [PW-1:0]    head, tail;
  logic [PW-1:0]    head_next, tail_next;
  logic [CW-1:0]    count, count_next;
  logic [CFG_W-1:0] capacity;
  logic             ok_r, ok_next;
  logic [CW-1:0]    cap_eff;
  logic             full, empty, accept, load;

  assign cap_eff = (32'(capacity) > DEPTH) ? CW'(DEPTH) : CW'(capacity);
  assign full    = count >= cap_eff;
  assign empty   = count == '0;
  assign s_ready = state == ST_IDLE;
  assign accept  = s_valid && s_ready;
  assign load    = (state == ST_CAPTURE) && (!m_valid || m_ready);

  // command decode; memory write lands on the accept edge
  always_comb begin
    head_next = head;
    tail_next = tail;
    count_next = count;
    ok_next = 1'b0;
    mem_we = 1'b0;
    mem_waddr = prev_slot(head);
    mem_wdata = DATA_WIDTH'(s_push_value);
    case (s_cmd)
      CMD_PUSH_FRONT: begin
        if (!full) begin
          head_next = prev_slot(head);
          count_next = count + 1'b1;
          mem_we = accept;
          ok_next = 1'b1;
        end
      end
      CMD_PUSH_REAR: begin
        if (!full) begin
          mem_waddr = tail;
          tail_next = next_slot(tail);
          count_next = count + 1'b1;
          mem_we = accept;
          ok_next = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (!empty) begin
          head_next = next_slot(head);
          count_next = count - 1'b1;
          ok_next = 1'b1;
        end
      end
      CMD_POP_REAR: begin
        if (!empty) begin
          tail_next = prev_slot(tail);
          count_next = count - 1'b1;
          ok_next = 1'b1;
        end
      end
      CMD_QUERY: ok_next = 1'b1;
      default: ok_next = 1'b0;
    endcase
  end

  assign mem_re      = state == ST_READ;
  assign mem_raddr_a = head;
  assign mem_raddr_b = prev_slot(tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0;
      tail <= '0;
      count <= '0;
      capacity <= CAPACITY_RESET;
      m_valid <= 1'b0;
      ok_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      // a reload in the same cycle keeps the output valid
      if (m_valid && m_ready && !load) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            head <= head_next;
            tail <= tail_next;
            count <= count_next;
            ok_r <= ok_next;
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_CAPTURE;
        ST_CAPTURE: begin
          if (load) begin
            m_valid <= 1'b1;
            m_result.ok <= ok_r;
            m_result.is_empty <= empty;
            m_result.is_full <= full;
            m_result.entry_count <= CFG_W'(count);
            m_result.front_value <= empty ? EMPTY_WORD : to_word(mem_rdata_a);
            m_result.rear_value <= empty ? EMPTY_WORD : to_word(mem_rdata_b);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/bounded_deque.sv =====
// An accepted input passes through the read state and the capture state before m_tvalid rises;
// capture waits while an earlier result is not taken. One transaction at a time, set by the
//   write / read / capture sequence through the entry memory (write on accept, read next, capture after).
// The next input is taken while a result waits in the output register.
// Reset (rst, synchronous): clears pointers, count and output valid, capacity
//   returns to 1024; the entry memory is not cleared, no clearing pass.
module bounded_deque #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration: capacity register
  input  logic                       cfg_we,
  input  logic [bdq_pkg::CFG_W-1:0]  cfg_wdata,
  // command stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // [31:0] push_value
  input  logic [7:0]                 s_tuser,   // [2:0] cmd, [7:3] zero
  // result stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [0] ok, [32:1] front_value, [64:33] rear_value, [65] is_empty,
  // [66] is_full, [77:67] entry_count, [79:78] zero
  output logic [79:0]                m_tdata
);
  import bdq_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic                  mem_we, mem_re;
  logic [PW-1:0]         mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;
  bdq_result_t           result;

  // pointers, count, capacity and the sequencer around the memory
  bdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .s_cmd        (s_tuser[CMD_W-1:0]),
    .s_push_value (s_tdata),
    .m_valid      (m_tvalid),
    .m_ready      (m_tready),
    .m_result     (result),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr_a  (mem_raddr_a),
    .mem_raddr_b  (mem_raddr_b),
    .mem_rdata_a  (mem_rdata_a),
    .mem_rdata_b  (mem_rdata_b)
  );

  // ring buffer storage: port a reads the front slot, port b the rear slot
  bdq_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  // result fields packed lowest first
  assign m_tdata = {2'b00, result.entry_count, result.is_full, result.is_empty,
                    result.rear_value, result.front_value, result.ok};

endmodule

// ===== hdl/bdq_checker.sv =====
`include "bounded_deque_defines.svh"

module bdq_checker #(
  parameter int DEPTH = 1024
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  `BDQ_ASSERT_RST(a_reset_clears_out, rst |=> !m_tvalid)
  `BDQ_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready)
  `BDQ_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
  `BDQ_ASSERT(a_count_flags, m_tvalid |-> ((m_tdata[65] == (m_tdata[77:67] == 11'd0)) && (32'(m_tdata[77:67]) <= DEPTH)))

endmodule

bind bounded_deque bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);

// ===== bench/bounded_deque_tb.sv =====
module bounded_deque_tb;
  import bdq_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int SHOWN_MAX   = 10;

  // codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  localparam logic [WORD_W-1:0] WORD_MAX_POS = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MAX_NEG = 32'h8000_0000;

  // Mirror of the deque: ring of slots, head/tail pointers, count and capacity.
  // Each accepted command produces one status transaction, queued in order.
  class deque_scoreboard;
    logic [WORD_W-1:0] slots [DEPTH];
    logic [9:0]        head;
    logic [9:0]        tail;
    int unsigned       held;
    logic [CFG_W-1:0]  capacity;
    bdq_result_t       due_status [$];
    int                mismatches;
    int                status_seen;

    function new();
      head = '0;
      tail = '0;
      held = 0;
      capacity = CAPACITY_RESET;
      mismatches = 0;
      status_seen = 0;
    endfunction

    function void load_capacity(logic [CFG_W-1:0] value);
      capacity = value;
    endfunction

    function int outstanding();
      return due_status.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= SHOWN_MAX) $display("%s", msg);
    endfunction

    // predicts the status for one accepted command
    function void note_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word);
      bdq_result_t st;
      int unsigned limit;
      logic [9:0]  last;
      bit          full_now;
      bit          empty_now;
      limit = (capacity > DEPTH) ? DEPTH : capacity;   // saturates at DEPTH
      full_now = held >= limit;
      empty_now = held == 0;
      st = '0;
      case (cmd)
        CMD_PUSH_FRONT: if (!full_now) begin
          head = head - 1'b1;
          slots[head] = word;
          held++;
          st.ok = 1'b1;
        end
        CMD_PUSH_REAR: if (!full_now) begin
          slots[tail] = word;
          tail = tail + 1'b1;
          held++;
          st.ok = 1'b1;
        end
        CMD_POP_FRONT: if (!empty_now) begin
          head = head + 1'b1;
          held--;
          st.ok = 1'b1;
        end
        CMD_POP_REAR: if (!empty_now) begin
          tail = tail - 1'b1;
          held--;
          st.ok = 1'b1;
        end
        CMD_QUERY: st.ok = 1'b1;
        default: ;  // reserved codes: no change, ok stays low
      endcase
      last = tail - 1'b1;
      if (held == 0) begin
        st.front_value = EMPTY_WORD;
        st.rear_value = EMPTY_WORD;
      end else begin
        st.front_value = slots[head];
        st.rear_value = slots[last];
      end
      st.is_empty = held == 0;
      st.is_full = held >= limit;
      st.entry_count = CFG_W'(held);
      due_status.push_back(st);
    endfunction

    function void compare_field(string field, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      if (got !== want)
        flag($sformatf("status %0d %s: expected %h, got %h", status_seen, field, want, got));
    endfunction

    function void check_status(logic [79:0] bits);
      bdq_result_t got;
      bdq_result_t want;
      got = bits[$bits(bdq_result_t)-1:0];
      status_seen++;
      if (due_status.size() == 0) begin
        flag($sformatf("status %0d arrived with nothing outstanding: %h", status_seen, bits));
        return;
      end
      want = due_status.pop_front();
      compare_field("ok", WORD_W'(want.ok), WORD_W'(got.ok));
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("rear_value", want.rear_value, got.rear_value);
      compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
      compare_field("is_full", WORD_W'(want.is_full), WORD_W'(got.is_full));
      compare_field("entry_count", WORD_W'(want.entry_count), WORD_W'(got.entry_count));
    endfunction

    function void close_out();
      if (due_status.size() != 0)
        flag($sformatf("%0d status transactions never arrived", due_status.size()));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;
  logic [7:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [79:0]       m_tdata;

  bit                hold_off_req = 1'b0;
  int                cycle_count;
  deque_scoreboard   sb = new();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bounded_deque #(.DEPTH(DEPTH), .DATA_WIDTH(WORD_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // status monitor: sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_status(m_tdata);
  end

  // Receiver: segments of always-ready, coin-flip and mostly-stalled.
  // A hold-off request drops tready for HOLD_CYCLES so the block backs up.
  initial begin
    int seg_left;
    int mode;
    seg_left = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(2, 0);
          seg_left = $urandom_range(120, 20);
        end
        seg_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(1, 0));
          default: m_tready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // All driving tasks start and end at a falling edge.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tuser <= {5'b0, cmd};
    s_tdata <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(cmd, word);
    @(negedge clk);
  endtask

  task automatic pause(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // stop sending and let every outstanding status transaction come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.load_capacity(value);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(int push_pct, bit noise);
    int r;
    r = $urandom_range(99, 0);
    if (noise && r < 4) return CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
    if (noise && r < 10) return CMD_QUERY;
    if ($urandom_range(99, 0) < push_pct)
      return $urandom_range(1, 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    return $urandom_range(1, 0) ? CMD_POP_REAR : CMD_POP_FRONT;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(15, 0))
      0: return '0;
      1: return WORD_MAX_POS;
      2: return WORD_MAX_NEG;
      3: return EMPTY_WORD;     // a stored -1 looks like empty, only the flag tells
      default: return $urandom();
    endcase
  endfunction

  // bursts of random length, short gaps between them
  task automatic run_random(int n, int push_pct, bit noise);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
      for (int i = 0; i < burst && sent < n; i++) begin
        send_item(pick_command(push_pct, noise), pick_word());
        sent++;
      end
      pause($urandom_range(6, 1));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty deque at reset capacity: refused pops, reserved codes
    send_item(CMD_QUERY, 32'h1234_5678);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_POP_REAR, EMPTY_WORD);
    send_item(CMD_RSVD_LO, WORD_MAX_POS);
    send_item(CMD_RSVD_HI, WORD_MAX_NEG);

    // small capacity: fill, refused push, pointer wrap both ways, drain
    set_capacity(11'd3);
    send_item(CMD_PUSH_FRONT, WORD_MAX_POS);   // head wraps below slot 0
    send_item(CMD_PUSH_REAR, WORD_MAX_NEG);
    send_item(CMD_PUSH_FRONT, '0);
    send_item(CMD_PUSH_REAR, EMPTY_WORD);      // full, refused
    send_item(CMD_RSVD_MID, 32'hA5A5_A5A5);
    send_item(CMD_POP_REAR, '0);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_POP_REAR, '0);               // empty, refused
    send_item(CMD_PUSH_REAR, EMPTY_WORD);
    send_item(CMD_PUSH_REAR, 32'h0000_0001);

    // capacity dropped under the count: nothing lost, pushes refused until the count falls below it
    set_capacity(11'd1);
    send_item(CMD_PUSH_FRONT, 32'h5A5A_5A5A);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_PUSH_REAR, 32'h5A5A_5A5A);
    send_item(CMD_POP_REAR, '0);
    send_item(CMD_PUSH_REAR, 32'h5555_AAAA);

    // zero capacity: empty and full together once drained
    set_capacity(11'd0);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_PUSH_FRONT, 32'hFFFF_0000);
    send_item(CMD_QUERY, '0);

    // random phases across a spread of capacities
    set_capacity(11'd2);
    run_random(70, 55, 1'b1);
    set_capacity(11'd1);
    run_random(50, 50, 1'b1);
    set_capacity(11'd5);
    run_random(35, 60, 1'b1);
    drain();                         // sender waits out every result mid-phase
    run_random(35, 60, 1'b1);
    set_capacity(11'd16);
    run_random(60, 70, 1'b1);
    run_random(60, 30, 1'b1);
    set_capacity(11'd0);
    run_random(30, 60, 1'b1);
    set_capacity(11'd64);
    hold_off_req = 1'b1;             // receiver stalls while commands keep coming
    run_random(80, 65, 1'b1);
    run_random(80, 35, 1'b1);
    set_capacity(CAPACITY_RESET);
    run_random(60, 50, 1'b1);
    set_capacity(11'd3);
    run_random(60, 30, 1'b1);

    // capacity above DEPTH saturates: push-heavy run, pushes keep succeeding
    set_capacity(11'd2047);
    run_random(60, 85, 1'b0);
    set_capacity(11'd1025);
    run_random(80, 25, 1'b1);

    drain();
    repeat (8) @(negedge clk);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
